// File: rtl/core/i2cbm_pkg.sv
// Package for the bit-level I2C master: command codes, queue descriptor and output phase types.
// Depends on nothing; the front, the queue, the back and the top level import it.
`default_nettype none

package i2cbm_pkg;

    // Command codes as they arrive on the command channel.
    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_READ     = 3'd3,
        CMD_SEND_ACK = 3'd4,
        CMD_RECV_ACK = 3'd5
    } t_cmd;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Decoded command as it waits in the queue.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] wbyte;
        logic       ack;
        logic [7:0] bus;
    } t_desc;

    // One pin phase as held in the output register.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sample_phase;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       last;
    } t_phase;

endpackage

`default_nettype wire

// File: rtl/core/i2cbm_if.sv
// Channel interfaces of the bit-level I2C master: the command channel and the phase channel.
// Depends on nothing; used by the front, the back and the top level.
`default_nettype none

// Command channel: one command item per handshake.
interface i2cbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       ack_to_send;
    logic [7:0] bus_levels;

    modport source (output valid, command, write_byte, ack_to_send, bus_levels, input ready);
    modport sink   (input valid, command, write_byte, ack_to_send, bus_levels, output ready);
endinterface

// Phase channel: one pin phase item per handshake.
interface i2cbm_phase_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sample_phase;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       last;

    modport source (output valid, scl_out, sda_out, sample_phase, read_byte, ack_seen, last,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, sample_phase, read_byte, ack_seen, last,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/i2cbm_front.sv
// Front of the bit-level I2C master: accepts command items and classifies them for the queue.
// Depends on i2cbm_pkg and i2cbm_cmd_if.
`default_nettype none

module i2cbm_front
    import i2cbm_pkg::*;
(
    i2cbm_cmd_if.sink i_cmd,
    input  wire logic i_q_full,
    output t_desc     o_desc,
    output logic      o_push
);

    logic w_accept;
    logic w_known;

    // An item is taken whenever the queue has room.
    assign i_cmd.ready = !i_q_full;
    assign w_accept    = i_cmd.valid && !i_q_full;

    // Unused command codes produce no phases, so they are dropped here.
    always_comb begin
        unique case (i_cmd.command)
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_SEND_ACK, CMD_RECV_ACK: begin
                w_known = 1'b1;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_push       = w_accept && w_known;
    assign o_desc.cmd   = t_cmd'(i_cmd.command);
    assign o_desc.wbyte = i_cmd.write_byte;
    assign o_desc.ack   = i_cmd.ack_to_send;
    assign o_desc.bus   = i_cmd.bus_levels;

endmodule

`default_nettype wire

// File: rtl/core/i2cbm_queue.sv
// Short register queue between the front and the back of the bit-level I2C master.
// Depends on i2cbm_pkg for the descriptor type.
`default_nettype none

module i2cbm_queue
    import i2cbm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_desc      i_desc,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_desc      o_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    // Pointers wrap at the depth, which need not be a power of two.
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    // The front must hold off while the queue is full, and the back only takes what is there.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// File: rtl/core/i2cbm_back.sv
// Back of the bit-level I2C master: steps through the pin phases of each queued command.
// Depends on i2cbm_pkg and i2cbm_phase_if; fed by i2cbm_queue.
`default_nettype none

module i2cbm_back
    import i2cbm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  t_desc           i_q_desc,
    output logic            o_q_pop,
    i2cbm_phase_if.source   o_phase
);

    // Current command and its position: bit index and sub-phase within the bit.
    logic        r_cur_valid;
    t_desc       r_desc;
    logic [2:0]  r_bit;
    logic [1:0]  r_sub;
    logic        r_scl;
    logic        r_sda;
    logic        r_out_valid;
    t_phase      r_out;

    logic        w_emit;
    logic        n_scl;
    logic        n_sda;
    logic        w_sample;
    logic        w_grp_end;
    logic        w_multi;
    t_phase      n_out;
    logic [2:0]  n_bit;
    logic [1:0]  n_sub;

    // A phase is produced whenever the output register is free or being emptied.
    assign w_emit  = r_cur_valid && (!r_out_valid || o_phase.ready);
    assign o_q_pop = i_q_valid && (!r_cur_valid || (w_emit && n_out.last));

    // Phase table: what each sub-phase of each command drives or samples.
    always_comb begin
        n_scl     = r_scl;
        n_sda     = r_sda;
        w_sample  = 1'b0;
        w_grp_end = 1'b0;
        w_multi   = 1'b0;
        unique case (r_desc.cmd)
            CMD_START: begin
                w_grp_end = (r_sub == 2'd3);
                unique case (r_sub)
                    2'd0: n_sda = 1'b1;
                    2'd1: n_scl = 1'b1;
                    2'd2: n_sda = 1'b0;
                    default: n_scl = 1'b0;
                endcase
            end
            CMD_STOP: begin
                w_grp_end = (r_sub == 2'd2);
                unique case (r_sub)
                    2'd0: n_sda = 1'b0;
                    2'd1: n_scl = 1'b1;
                    default: n_sda = 1'b1;
                endcase
            end
            CMD_WRITE: begin
                w_multi   = 1'b1;
                w_grp_end = (r_sub == 2'd2);
                unique case (r_sub)
                    2'd0: n_sda = r_desc.wbyte[3'd7 - r_bit];
                    2'd1: n_scl = 1'b1;
                    default: n_scl = 1'b0;
                endcase
            end
            CMD_READ: begin
                // Sub-phase three is the one release of SDA before the first bit.
                w_multi   = 1'b1;
                w_grp_end = (r_sub == 2'd2);
                unique case (r_sub)
                    2'd0: n_scl = 1'b1;
                    2'd1: w_sample = 1'b1;
                    2'd2: n_scl = 1'b0;
                    default: n_sda = 1'b1;
                endcase
            end
            CMD_SEND_ACK: begin
                w_grp_end = (r_sub == 2'd2);
                unique case (r_sub)
                    2'd0: n_sda = r_desc.ack;
                    2'd1: n_scl = 1'b1;
                    default: n_scl = 1'b0;
                endcase
            end
            CMD_RECV_ACK: begin
                w_grp_end = (r_sub == 2'd3);
                unique case (r_sub)
                    2'd0: n_sda = 1'b1;
                    2'd1: n_scl = 1'b1;
                    2'd2: w_sample = 1'b1;
                    default: n_scl = 1'b0;
                endcase
            end
            default: begin
                w_grp_end = 1'b1;
            end
        endcase
    end

    // Assemble the outgoing phase; the received byte is the bus levels given with the command.
    always_comb begin
        n_out.scl_out      = n_scl;
        n_out.sda_out      = n_sda;
        n_out.sample_phase = w_sample;
        n_out.last         = w_grp_end && (!w_multi || (r_bit == 3'd7));
        n_out.read_byte    = (r_desc.cmd == CMD_READ && n_out.last) ? r_desc.bus : 8'd0;
        n_out.ack_seen     = (r_desc.cmd == CMD_RECV_ACK && n_out.last) && r_desc.bus[0];
    end

    // Position advance within the command.
    always_comb begin
        if (w_grp_end) begin
            n_sub = 2'd0;
            n_bit = r_bit + 3'd1;
        end else begin
            n_sub = r_sub + 2'd1;
            n_bit = r_bit;
        end
    end

    // Control state and bus levels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_bit       <= 3'd0;
            r_sub       <= 2'd0;
        end else begin
            if (o_q_pop) begin
                r_cur_valid <= 1'b1;
                r_bit       <= 3'd0;
                r_sub       <= (i_q_desc.cmd == CMD_READ) ? 2'd3 : 2'd0;
            end else if (w_emit) begin
                r_cur_valid <= !n_out.last;
                r_bit       <= n_bit;
                r_sub       <= n_sub;
            end
            if (w_emit) begin
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (o_phase.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_desc <= i_q_desc;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_phase.valid        = r_out_valid;
    assign o_phase.scl_out      = r_out.scl_out;
    assign o_phase.sda_out      = r_out.sda_out;
    assign o_phase.sample_phase = r_out.sample_phase;
    assign o_phase.read_byte    = r_out.read_byte;
    assign o_phase.ack_seen     = r_out.ack_seen;
    assign o_phase.last         = r_out.last;

    // Received data only ever appear on the closing phase of a run.
    a_ack_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ack_seen) |-> r_out.last)
        else $error("ack bit outside the last phase");

    a_byte_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.read_byte != 8'd0)) |-> r_out.last)
        else $error("read byte outside the last phase");

    // A sampling phase never moves the clock or data line.
    a_sample_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_sample) |=> ($stable(r_scl) && $stable(r_sda)))
        else $error("pin level changed in a sampling phase");

endmodule

`default_nettype wire

// File: rtl/core/i2c_bit_level_master_unit.sv
// Top level of the bit-level I2C master: front, command queue and phase sequencer.
// Depends on i2cbm_pkg, i2cbm_if, i2cbm_front, i2cbm_queue and i2cbm_back.
//
// Usage: each item on i_cmd is one bus command (start, stop, write byte, read byte,
// send ack, receive ack). For it the block emits its run of pin phases on o_phase,
// one phase per item, with last set on the final one. Read data and the ack bit
// come from bus_levels and appear on that final phase. Unused command codes are
// accepted and produce nothing.
// An accepted command passes through the queue and the current-command register,
// and each phase leaves from the output register. Throughput: one phase per cycle
// while the receiver is ready; the phases of a command number 4 for start, 3 for stop,
// 24 for write byte, 25 for read byte, 3 for send ack and 4 for receive ack.
// Runs of consecutive commands follow each other without a gap.
// i_cmd is ready while the command queue (QUEUE_DEPTH entries) has room, so new
// commands are taken while earlier ones are still being sequenced.
// Reset clears the queue and the output register and returns SCL and SDA to the
// released level. When the receiver stalls, the current phase is held in the output
// register and the sequencer waits; the queue then fills and i_cmd drops ready.
`default_nettype none

module i2c_bit_level_master_unit
    import i2cbm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    i2cbm_cmd_if.sink     i_cmd,
    i2cbm_phase_if.source o_phase
);

    t_desc w_front_desc;
    logic  w_push;
    logic  w_q_full;
    logic  w_q_valid;
    t_desc w_q_desc;
    logic  w_q_pop;

    // Front: takes and classifies command items.
    i2cbm_front u_front (
        .i_cmd    (i_cmd),
        .i_q_full (w_q_full),
        .o_desc   (w_front_desc),
        .o_push   (w_push)
    );

    // Queue decoupling the front from the sequencer.
    i2cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_front_desc),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc)
    );

    // Back: steps through pin phases.
    i2cbm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_desc  (w_q_desc),
        .o_q_pop   (w_q_pop),
        .o_phase   (o_phase)
    );

endmodule

`default_nettype wire
